// File: design/assert_macros.svh
// Assertion macros used by the pump load controller.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks that a condition holds at every clock edge out of reset.
`define PLC_ASSERT(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Checks that a consequent holds whenever an antecedent holds.
`define PLC_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`endif

// File: design/plc_pkg.sv
// Types, codes and constants of the pump load controller.
`timescale 1ns / 1ps

package plc_pkg;

  typedef logic [2:0] action_t;
  typedef logic [1:0] src_t;
  typedef logic [2:0] lstate_t;
  typedef logic [1:0] mode_t;
  typedef logic [1:0] status_t;
  typedef logic [1:0] cmd_t;
  typedef logic [1:0] cfg_idx_t;

  localparam action_t ACT_LOAD_ON  = 3'd0;
  localparam action_t ACT_LOAD_OFF = 3'd1;
  localparam action_t ACT_OP_START = 3'd2;
  localparam action_t ACT_OP_STOP  = 3'd3;
  localparam action_t ACT_SET_LOCK = 3'd4;
  localparam action_t ACT_TICK     = 3'd5;
  localparam action_t ACT_CONSUME  = 3'd6;

  localparam src_t SRC_UNKNOWN = 2'd0;
  localparam src_t SRC_AUTO    = 2'd1;
  localparam src_t SRC_SOLAR   = 2'd2;
  localparam src_t SRC_GRID    = 2'd3;

  localparam lstate_t LS_IDLE    = 3'd0;
  localparam lstate_t LS_RUNNING = 3'd1;
  localparam lstate_t LS_STUCK   = 3'd2;
  localparam lstate_t LS_NOSRC   = 3'd3;
  localparam lstate_t LS_TIMEOUT = 3'd4;

  localparam mode_t MODE_AUTO   = 2'd0;
  localparam mode_t MODE_MANUAL = 2'd1;
  localparam mode_t MODE_FULL   = 2'd2;

  localparam status_t ST_OK    = 2'd0;
  localparam status_t ST_STATE = 2'd1;
  localparam status_t ST_ARG   = 2'd2;
  localparam status_t ST_FAIL  = 2'd3;

  localparam cmd_t CMD_NONE = 2'd0;
  localparam cmd_t CMD_OFF  = 2'd1;
  localparam cmd_t CMD_ON   = 2'd2;

  localparam cfg_idx_t CFG_DEFAULT_WD = 2'd0;
  localparam cfg_idx_t CFG_OUT_VALID  = 2'd1;
  localparam cfg_idx_t CFG_NOM_POWER  = 2'd2;

  localparam int MS_PER_S = 1000;

  // Reciprocal of 1000 for the runtime split: exact for any 17-bit sum.
  localparam int RT_SHIFT = 26;
  localparam logic [16:0] RT_RECIP = 17'((64'd1 << RT_SHIFT) / MS_PER_S + 1);

  // Reciprocal of 1000 for the watchdog readout: exact for any 27-bit value.
  localparam int WD_SHIFT = 36;
  localparam logic [26:0] WD_RECIP = 27'((64'd1 << WD_SHIFT) / MS_PER_S + 1);

  function automatic logic real_src(input src_t s);
    return (s == SRC_SOLAR) || (s == SRC_GRID);
  endfunction

endpackage

// File: design/pump_load_controller.sv
// Pump load controller top level: action decode, state registers and result register.
// The result word for an accepted input word is registered and appears in the cycle after acceptance.
// Throughput: one word per cycle; the only stall is a result word not yet taken.
// All work for a word is one pass of logic between the state and the result register.
// Synchronous active-low reset returns the load to idle in auto mode with no source,
// clears runtime and watchdog, sets the changed flag and restores register defaults.
`timescale 1ns / 1ps

module pump_load_controller (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  plc_pkg::cfg_idx_t cfg_index,
  input  logic [15:0] cfg_wdata,
  input  logic        in_tvalid,
  output logic        in_tready,
  // action [2:0]
  input  logic [2:0]  in_tuser,
  // request_source [1:0], wd_timeout_s [17:2], elapsed_ms [33:18],
  // output_energized [34], activate_ok [35], zero fill [39:36]
  input  logic [39:0] in_tdata,
  output logic        out_tvalid,
  input  logic        out_tready,
  // status [1:0], contactor_cmd [3:2], contactor_source [5:4], load_state [8:6],
  // mode [10:9], locked_src [12:11], feed_src [14:13],
  // power_w [30:15], run_time_s [62:31], wd_left_s [78:63],
  // changed [79]
  output logic [79:0] out_tdata
);
  import plc_pkg::*;
  `include "assert_macros.svh"

  logic [15:0] default_wd_r;
  logic        out_valid_cfg_r;
  logic [15:0] nom_power_r;

  lstate_t     ls_r, ls_nxt;
  mode_t       mode_r, mode_nxt;
  src_t        as_r, as_nxt;
  src_t        locked_r, locked_nxt;
  logic [31:0] rt_s_r, rt_s_nxt;
  logic [9:0]  rt_ms_r, rt_ms_nxt;
  logic [25:0] wd_r, wd_nxt;
  logic        changed_r, changed_nxt;

  logic        out_valid_r;
  logic [79:0] out_data_r;

  action_t     action;
  src_t        req;
  logic [15:0] wd_s;
  logic [15:0] delta;
  logic        energized;
  logic        act_ok;
  logic        accept;
  logic        stuck;

  src_t        target;
  logic [15:0] wd_t;
  logic [25:0] wd_t_ms;
  logic [25:0] wd_base;
  logic        wd_set;

  logic [16:0] rt_sum;
  logic [33:0] rt_prod;
  logic [6:0]  rt_q;
  logic [16:0] rt_rem;

  logic [26:0] wd_round;
  logic [53:0] wd_prod;
  logic [15:0] wd_rem_s;

  status_t     status;
  cmd_t        cmd;
  src_t        csrc;
  logic        mv_req;
  lstate_t     mv_state;
  logic        set_changed;
  logic        moved;
  lstate_t     ls_tmp;
  src_t        as_tmp;
  logic        changed_post;
  src_t        selected;
  logic [15:0] power;
  logic [15:0] remaining;

  assign action    = in_tuser;
  assign req       = in_tdata[1:0];
  assign wd_s      = in_tdata[17:2];
  assign delta     = in_tdata[33:18];
  assign energized = in_tdata[34];
  assign act_ok    = in_tdata[35];

  assign in_tready  = !out_valid_r || out_tready;
  assign accept     = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  assign stuck   = out_valid_cfg_r && energized;
  assign target  = real_src(locked_r) ? locked_r : req;
  assign wd_t    = (wd_s != 16'd0) ? wd_s : default_wd_r;
  assign wd_t_ms = 26'(wd_t) * 26'(MS_PER_S);

  assign rt_sum  = 17'(rt_ms_r) + 17'(delta);
  assign rt_prod = 34'(rt_sum) * 34'(RT_RECIP);
  assign rt_q    = rt_prod[RT_SHIFT +: 7];
  assign rt_rem  = rt_sum - 17'(rt_q) * 17'(MS_PER_S);

  always_comb begin
    status      = ST_OK;
    cmd         = CMD_NONE;
    csrc        = SRC_UNKNOWN;
    mode_nxt    = mode_r;
    locked_nxt  = locked_r;
    rt_s_nxt    = rt_s_r;
    rt_ms_nxt   = rt_ms_r;
    wd_base     = wd_r;
    wd_set      = 1'b0;
    mv_req      = 1'b0;
    mv_state    = ls_r;
    set_changed = 1'b0;
    as_tmp      = as_r;
    ls_tmp      = ls_r;
    case (action)
      ACT_LOAD_ON: begin
        if (mode_r == MODE_MANUAL || mode_r == MODE_FULL) begin
          status = ST_STATE;
        end else if (!real_src(target)) begin
          status = ST_ARG;
        end else if (ls_r == LS_RUNNING && as_r == target) begin
          wd_set = 1'b1;
        end else if (stuck) begin
          mv_req   = 1'b1;
          mv_state = LS_STUCK;
          cmd      = CMD_OFF;
          status   = ST_STATE;
        end else begin
          cmd  = CMD_ON;
          csrc = target;
          if (!act_ok) begin
            mv_req   = 1'b1;
            mv_state = LS_NOSRC;
            status   = ST_FAIL;
          end else begin
            rt_s_nxt  = 32'd0;
            rt_ms_nxt = 10'd0;
            wd_set    = 1'b1;
            mode_nxt  = MODE_AUTO;
            ls_tmp    = LS_RUNNING;
            as_tmp    = target;
          end
        end
      end
      ACT_LOAD_OFF: begin
        if (mode_r == MODE_FULL) begin
          status = ST_STATE;
        end else begin
          cmd      = CMD_OFF;
          wd_base  = 26'd0;
          mode_nxt = MODE_AUTO;
          mv_req   = 1'b1;
          mv_state = LS_IDLE;
        end
      end
      ACT_OP_START: begin
        if (!real_src(req)) begin
          status = ST_ARG;
        end else if (stuck) begin
          mv_req   = 1'b1;
          mv_state = LS_STUCK;
          cmd      = CMD_OFF;
          status   = ST_STATE;
        end else if (ls_r == LS_RUNNING && as_r == req) begin
          mode_nxt    = MODE_MANUAL;
          set_changed = 1'b1;
        end else begin
          cmd  = CMD_ON;
          csrc = req;
          if (!act_ok) begin
            mv_req   = 1'b1;
            mv_state = LS_NOSRC;
            status   = ST_FAIL;
          end else begin
            rt_s_nxt  = 32'd0;
            rt_ms_nxt = 10'd0;
            wd_base   = 26'd0;
            mode_nxt  = MODE_MANUAL;
            ls_tmp    = LS_RUNNING;
            as_tmp    = req;
          end
        end
      end
      ACT_OP_STOP: begin
        cmd      = CMD_OFF;
        wd_base  = 26'd0;
        mode_nxt = MODE_AUTO;
        mv_req   = 1'b1;
        mv_state = LS_IDLE;
      end
      ACT_SET_LOCK: begin
        if (locked_r != req) begin
          locked_nxt  = req;
          set_changed = 1'b1;
          if (!real_src(req)) begin
            if (mode_r == MODE_MANUAL) begin
              mode_nxt = MODE_AUTO;
            end
          end else if (ls_r == LS_RUNNING && as_r != req) begin
            cmd  = CMD_ON;
            csrc = req;
            if (act_ok) begin
              as_tmp = req;
            end else begin
              mv_req   = 1'b1;
              mv_state = LS_NOSRC;
            end
          end
        end
      end
      ACT_TICK: begin
        if (ls_r == LS_RUNNING) begin
          rt_s_nxt  = rt_s_r + 32'(rt_q);
          rt_ms_nxt = rt_rem[9:0];
          if (wd_r != 26'd0) begin
            if (26'(delta) >= wd_r) begin
              wd_base  = 26'd0;
              cmd      = CMD_OFF;
              mode_nxt = MODE_AUTO;
              mv_req   = 1'b1;
              mv_state = LS_TIMEOUT;
            end else begin
              wd_base = wd_r - 26'(delta);
            end
          end
        end
      end
      default: begin
      end
    endcase
  end

  // Every move other than to running also drops the active source.
  always_comb begin
    ls_nxt = ls_tmp;
    as_nxt = as_tmp;
    moved  = 1'b0;
    if (mv_req) begin
      ls_nxt = mv_state;
      as_nxt = SRC_UNKNOWN;
      moved  = (ls_r != mv_state) || (as_r != SRC_UNKNOWN);
    end else if (ls_tmp != ls_r || as_tmp != as_r) begin
      moved = (ls_tmp == LS_RUNNING);
    end
  end

  assign changed_post = changed_r || set_changed || moved;
  assign changed_nxt  = (action == ACT_CONSUME) ? 1'b0 : changed_post;
  assign wd_nxt       = wd_set ? wd_t_ms : wd_base;

  assign wd_round  = 27'(wd_base) + 27'(MS_PER_S - 1);
  assign wd_prod   = 54'(wd_round) * 54'(WD_RECIP);
  assign wd_rem_s  = wd_prod[WD_SHIFT +: 16];
  assign remaining = wd_set ? wd_t : wd_rem_s;

  assign selected = (locked_nxt == SRC_UNKNOWN) ? SRC_AUTO : locked_nxt;
  assign power    = (ls_nxt == LS_RUNNING) ? nom_power_r : 16'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      default_wd_r    <= 16'd300;
      out_valid_cfg_r <= 1'b1;
      nom_power_r     <= 16'd0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_DEFAULT_WD: default_wd_r    <= cfg_wdata;
        CFG_OUT_VALID:  out_valid_cfg_r <= cfg_wdata[0];
        CFG_NOM_POWER:  nom_power_r     <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ls_r      <= LS_IDLE;
      mode_r    <= MODE_AUTO;
      as_r      <= SRC_UNKNOWN;
      locked_r  <= SRC_UNKNOWN;
      rt_s_r    <= 32'd0;
      rt_ms_r   <= 10'd0;
      wd_r      <= 26'd0;
      changed_r <= 1'b1;
    end else if (accept) begin
      ls_r      <= ls_nxt;
      mode_r    <= mode_nxt;
      as_r      <= as_nxt;
      locked_r  <= locked_nxt;
      rt_s_r    <= rt_s_nxt;
      rt_ms_r   <= rt_ms_nxt;
      wd_r      <= wd_nxt;
      changed_r <= changed_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_tready) begin
      out_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_data_r <= {changed_post, remaining, rt_s_nxt, power, as_nxt, selected,
                     mode_nxt, ls_nxt, csrc, cmd, status};
    end
  end

  `PLC_ASSERT(a_ms_range, rt_ms_r < 10'(MS_PER_S), "runtime milliseconds out of range")
  `PLC_ASSERT_IMP(a_run_src, ls_r == LS_RUNNING, real_src(as_r),
                  "running without a real source")
  `PLC_ASSERT_IMP(a_power, out_valid_r && out_data_r[30:15] != 16'd0,
                  out_data_r[8:6] == LS_RUNNING, "power reported while not running")
  `PLC_ASSERT_IMP(a_csrc, out_valid_r && out_data_r[5:4] != SRC_UNKNOWN,
                  out_data_r[3:2] == CMD_ON, "contactor source without activation")

endmodule
